/* rtl/vertex_transform_4x4_macros.svh */
// ----------------------------------------------------------------------------
// Vertex transform assertion macros
// Shared concurrent assertion forms for the vertex transform checker.
// ----------------------------------------------------------------------------
`ifndef VERTEX_TRANSFORM_4X4_MACROS_SVH
`define VERTEX_TRANSFORM_4X4_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VT4_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vt4 check failed: same-cycle rule");

// Consequent must hold in the cycle after the antecedent.
`define VT4_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vt4 check failed: next-cycle rule");

`endif

/* rtl/vt4_pkg.sv */
// ----------------------------------------------------------------------------
// Vertex transform package
// Operation codes and transaction payload types of the vertex transform.
// ----------------------------------------------------------------------------
`default_nettype none

package vt4_pkg;

   localparam int FIELD_W = 32;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_XFORM = 1'b1
   } vt4_op_type;

   typedef struct packed {
      vt4_op_type                 operation;
      logic [1:0]                 row;
      logic [1:0]                 col;
      logic signed [FIELD_W-1:0]  element;
      logic signed [FIELD_W-1:0]  in_x;
      logic signed [FIELD_W-1:0]  in_y;
      logic signed [FIELD_W-1:0]  in_z;
      logic signed [FIELD_W-1:0]  in_w;
   } vt4_req_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0]  out_x;
      logic signed [FIELD_W-1:0]  out_y;
      logic signed [FIELD_W-1:0]  out_z;
      logic signed [FIELD_W-1:0]  out_w;
      logic                       saturated;
   } vt4_rsp_type;

endpackage

`default_nettype wire

/* rtl/vt4_stream_if.sv */
// ----------------------------------------------------------------------------
// Vertex transform stream interface
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface vt4_stream_if #(
   parameter type payload_type = logic
);

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);

endinterface

`default_nettype wire

/* rtl/vertex_transform_4x4.sv */
// ----------------------------------------------------------------------------
// Vertex transform 4x4
// Multiplies a stored 4x4 fixed-point matrix by a stream of 4-component vectors.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one transaction per handshake (valid and ready high at a
//   rising clock edge). An element-write transaction stores element at
//   (row, col) and produces no response; the next accepted transaction
//   already sees the new element. A transform transaction produces one
//   response on rsp_if: the matrix times (in_x, in_y, in_z, in_w), each row
//   shifted right by FRAC_BITS and clamped to DATA_WIDTH bits, with the
//   saturated flag set if any component was clamped.
//   Throughput: one transaction per cycle while req_if.ready is high. The
//   accepting edge loads the partial-product register; full products, row
//   sums and the clamped output each add one more register stage.
//   Reset (synchronous, active high) loads the identity matrix and empties
//   the pipeline. When the receiver stalls, the response holds and the
//   pipeline keeps filling its empty stages; req_if.ready drops only once
//   all four stages hold a transform.
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_transform_4x4 #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   vt4_stream_if.sink      req_if,
   vt4_stream_if.source    rsp_if
);

   // Multiplier split: the vector operand is cut into a low unsigned half and
   // a high signed half so no single multiplier exceeds DATA_WIDTH x HALF+1.
   localparam int HALF   = DATA_WIDTH / 2;
   localparam int HI_W   = DATA_WIDTH - HALF;
   localparam int PL_W   = DATA_WIDTH + HALF + 1;
   localparam int PH_W   = DATA_WIDTH + HI_W;
   localparam int PROD_W = 2 * DATA_WIDTH;
   localparam int SUM_W  = 2 * DATA_WIDTH + 2;

   typedef logic signed [DATA_WIDTH-1:0] word_type;

   localparam word_type ONE_V = word_type'(64'd1 << FRAC_BITS);
   localparam word_type MAX_V = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam word_type MIN_V = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   // Matrix, entry row*4+col
   word_type                 matrix_ff [16];

   // Pipeline registers
   logic                     prt_valid_ff;
   logic signed [PL_W-1:0]   plo_ff [16];
   logic signed [PH_W-1:0]   phi_ff [16];
   logic                     prd_valid_ff;
   logic signed [PROD_W-1:0] prod_ff [16];
   logic                     sum_valid_ff;
   logic signed [SUM_W-1:0]  sum_ff [4];
   logic                     out_valid_ff;
   vt4_pkg::vt4_rsp_type     rsp_ff;

   // Next values and helpers
   word_type                 vec [4];
   logic signed [HALF:0]     vlo [4];
   logic signed [HI_W-1:0]   vhi [4];
   logic signed [PL_W-1:0]   plo_in [16];
   logic signed [PH_W-1:0]   phi_in [16];
   logic signed [PROD_W-1:0] prod_in [16];
   logic signed [SUM_W-1:0]  sum_in [4];
   logic signed [SUM_W-1:0]  shifted [4];
   logic [3:0]               clamped;
   word_type                 clamp_val [4];
   vt4_pkg::vt4_rsp_type     rsp_in;

   logic                     out_free;
   logic                     sum_free;
   logic                     prd_free;
   logic                     prt_free;
   logic                     accept;
   logic                     is_write;

   // Flow control: each stage takes new data when empty or when it drains.
   assign out_free = !out_valid_ff || rsp_if.ready;
   assign sum_free = !sum_valid_ff || out_free;
   assign prd_free = !prd_valid_ff || sum_free;
   assign prt_free = !prt_valid_ff || prd_free;

   assign req_if.ready = prt_free;
   assign accept       = req_if.valid && prt_free;
   assign is_write     = (req_if.payload.operation == vt4_pkg::OP_WRITE);

   assign rsp_if.valid   = out_valid_ff;
   assign rsp_if.payload = rsp_ff;

   // Input vector, narrowed or sign-extended to DATA_WIDTH
   always_comb begin
      vec[0] = word_type'(req_if.payload.in_x);
      vec[1] = word_type'(req_if.payload.in_y);
      vec[2] = word_type'(req_if.payload.in_z);
      vec[3] = word_type'(req_if.payload.in_w);
      for (int c = 0; c < 4; c++) begin
         vlo[c] = {1'b0, vec[c][HALF-1:0]};
         vhi[c] = vec[c][DATA_WIDTH-1:HALF];
      end
   end

   // Stage 1: partial products straight from the accepted transaction
   always_comb begin
      for (int i = 0; i < 16; i++) begin
         plo_in[i] = PL_W'(matrix_ff[i]) * PL_W'(vlo[i % 4]);
         phi_in[i] = PH_W'(matrix_ff[i]) * PH_W'(vhi[i % 4]);
      end
   end

   // Stage 2: recombine halves into full products
   always_comb begin
      for (int i = 0; i < 16; i++) begin
         prod_in[i] = (PROD_W'(phi_ff[i]) <<< HALF) + PROD_W'(plo_ff[i]);
      end
   end

   // Stage 3: row sums, exact
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         sum_in[r] = SUM_W'(prod_ff[4*r])     + SUM_W'(prod_ff[4*r + 1])
                   + SUM_W'(prod_ff[4*r + 2]) + SUM_W'(prod_ff[4*r + 3]);
      end
   end

   // Stage 4: drop fraction bits (floor) and clamp to DATA_WIDTH
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         shifted[r] = sum_ff[r] >>> FRAC_BITS;
         clamped[r] = !((&shifted[r][SUM_W-1:DATA_WIDTH-1])
                     || !(|shifted[r][SUM_W-1:DATA_WIDTH-1]));
         if (!clamped[r]) begin
            clamp_val[r] = shifted[r][DATA_WIDTH-1:0];
         end else if (shifted[r][SUM_W-1]) begin
            clamp_val[r] = MIN_V;
         end else begin
            clamp_val[r] = MAX_V;
         end
      end
      rsp_in.out_x     = vt4_pkg::FIELD_W'(clamp_val[0]);
      rsp_in.out_y     = vt4_pkg::FIELD_W'(clamp_val[1]);
      rsp_in.out_z     = vt4_pkg::FIELD_W'(clamp_val[2]);
      rsp_in.out_w     = vt4_pkg::FIELD_W'(clamp_val[3]);
      rsp_in.saturated = |clamped;
   end

   // Matrix: identity at reset, element writes at acceptance
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            matrix_ff[i] <= (i % 5 == 0) ? ONE_V : '0;
         end
      end else if (accept && is_write) begin
         matrix_ff[{req_if.payload.row, req_if.payload.col}] <=
            word_type'(req_if.payload.element);
      end
   end

   // Pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         prt_valid_ff <= 1'b0;
         prd_valid_ff <= 1'b0;
         sum_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (prt_free) begin
            prt_valid_ff <= accept && !is_write;
         end
         if (prd_free) begin
            prd_valid_ff <= prt_valid_ff;
         end
         if (sum_free) begin
            sum_valid_ff <= prd_valid_ff;
         end
         if (out_free) begin
            out_valid_ff <= sum_valid_ff;
         end
      end
   end

   // Pipeline payload, advanced only when the stage takes new data
   always_ff @(posedge clock) begin
      if (prt_free) begin
         plo_ff <= plo_in;
         phi_ff <= phi_in;
      end
      if (prd_free) begin
         prod_ff <= prod_in;
      end
      if (sum_free) begin
         sum_ff <= sum_in;
      end
      if (out_free && sum_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/vt4_checker.sv */
// ----------------------------------------------------------------------------
// Vertex transform checker
// Port-level assertions on the vertex transform, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "vertex_transform_4x4_macros.svh"

module vt4_checker #(
   parameter int DATA_WIDTH = 32
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_ready,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire vt4_pkg::vt4_rsp_type  rsp_payload
);

   localparam logic signed [DATA_WIDTH-1:0] MAX_V = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DATA_WIDTH-1:0] MIN_V = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam logic signed [31:0] MAX_OUT = 32'(MAX_V);
   localparam logic signed [31:0] MIN_OUT = 32'(MIN_V);

   logic sat_shape;

   assign sat_shape = rsp_payload.out_x == MAX_OUT || rsp_payload.out_x == MIN_OUT
                   || rsp_payload.out_y == MAX_OUT || rsp_payload.out_y == MIN_OUT
                   || rsp_payload.out_z == MAX_OUT || rsp_payload.out_z == MIN_OUT
                   || rsp_payload.out_w == MAX_OUT || rsp_payload.out_w == MIN_OUT;

   // Pipeline comes out of reset empty and open
   `VT4_ASSERT_SAME(a_reset_empty, clock, reset, $past(reset), req_ready && !rsp_valid)

   // No backpressure unless the output is blocked
   `VT4_ASSERT_SAME(a_no_idle_stall, clock, reset, !rsp_valid || rsp_ready, req_ready)

   // A clamped response carries at least one rail value
   `VT4_ASSERT_SAME(a_sat_rail, clock, reset, rsp_valid && rsp_payload.saturated, sat_shape)

   // Response valid held while stalled
   `VT4_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

endmodule

bind vertex_transform_4x4 vt4_checker #(
   .DATA_WIDTH (DATA_WIDTH)
) u_vt4_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_payload (rsp_if.payload)
);

`default_nettype wire
